// ===== hw/rtl/mlrq_pkg.sv =====
// Shared types and constants of the multilevel ready-queue scheduler.
package mlrq_pkg;

    localparam int OP_W  = 3;
    localparam int PID_W = 8;
    localparam int CPU_W = 4;

    // Nominal queue levels, clamped to the configured level count.
    localparam int LEVEL_NEW     = 0;
    localparam int LEVEL_EXPIRED = 1;
    localparam int LEVEL_IO      = 2;

    typedef enum logic [OP_W-1:0] {
        OP_NEW     = 3'd0,
        OP_IO_DONE = 3'd1,
        OP_EXPIRE  = 3'd2,
        OP_YIELD   = 3'd3,
        OP_IDLE    = 3'd4
    } t_opcode;

    // Queue bank request for one executing word.
    typedef struct packed {
        logic push_new;
        logic push_io;
        logic push_exp;
        logic pop;
    } t_lvl_ctl;

    // Queue bank answer: a process was found, and whether it is the one pushed just now.
    typedef struct packed {
        logic found;
        logic bypass;
    } t_lvl_stat;

endpackage

// ===== hw/rtl/mlrq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module mlrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 768,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/mlrq_levels.sv =====
// Head, tail and occupancy of every ready level, with push and pop selection.
module mlrq_levels #(
    parameter int NUM_PROCS = 256,
    parameter int NUM_LEVELS = 3,
    localparam int PTR_W = $clog2(NUM_PROCS),
    localparam int LVL_W = $clog2(NUM_LEVELS),
    localparam int ADDR_W = LVL_W + PTR_W
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mlrq_pkg::t_lvl_ctl   i_ctl,
    output mlrq_pkg::t_lvl_stat  o_stat,
    output logic                 o_we,
    output logic [ADDR_W-1:0]    o_waddr,
    output logic                 o_re,
    output logic [ADDR_W-1:0]    o_raddr
);

    localparam int CNT_W = $clog2(NUM_PROCS + 1);
    localparam int LVL_EXP = (mlrq_pkg::LEVEL_EXPIRED < NUM_LEVELS) ?
                             mlrq_pkg::LEVEL_EXPIRED : NUM_LEVELS - 1;
    localparam int LVL_IO  = (mlrq_pkg::LEVEL_IO < NUM_LEVELS) ?
                             mlrq_pkg::LEVEL_IO : NUM_LEVELS - 1;
    localparam logic [CNT_W-1:0] FULL     = CNT_W'(NUM_PROCS);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(NUM_PROCS - 1);

    logic [PTR_W-1:0]  r_head  [NUM_LEVELS];
    logic [PTR_W-1:0]  r_tail  [NUM_LEVELS];
    logic [CNT_W-1:0]  r_count [NUM_LEVELS];

    logic [LVL_W-1:0]      push_lvl;
    logic                  any_push;
    logic [NUM_LEVELS-1:0] push_ok;
    logic [NUM_LEVELS-1:0] nonempty;
    logic [NUM_LEVELS-1:0] pop_ok;
    logic [LVL_W-1:0]      pop_lvl;
    logic                  found;
    logic                  bypass;
    logic [PTR_W-1:0]      head_sel;
    logic [PTR_W-1:0]      tail_sel;

    // Pick the push level and check room
    always_comb begin
        any_push = i_ctl.push_new | i_ctl.push_io | i_ctl.push_exp;
        if (i_ctl.push_new) begin
            push_lvl = LVL_W'(mlrq_pkg::LEVEL_NEW);
        end else if (i_ctl.push_exp) begin
            push_lvl = LVL_W'(LVL_EXP);
        end else begin
            push_lvl = LVL_W'(LVL_IO);
        end
        for (int l = 0; l < NUM_LEVELS; l++) begin
            push_ok[l]  = any_push && (push_lvl == LVL_W'(l)) && (r_count[l] != FULL);
            nonempty[l] = (r_count[l] != '0) || push_ok[l];
        end
    end

    // Find the most urgent non-empty level, counting the word pushed now
    always_comb begin
        found   = 1'b0;
        pop_lvl = '0;
        for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
            if (nonempty[l]) begin
                found   = 1'b1;
                pop_lvl = LVL_W'(l);
            end
        end
        bypass   = 1'b0;
        head_sel = '0;
        tail_sel = '0;
        for (int l = 0; l < NUM_LEVELS; l++) begin
            pop_ok[l] = i_ctl.pop && found && (pop_lvl == LVL_W'(l));
            bypass    = bypass | (pop_ok[l] && (r_count[l] == '0));
            head_sel  = head_sel | (pop_ok[l] ? r_head[l] : '0);
            tail_sel  = tail_sel | (push_ok[l] ? r_tail[l] : '0);
        end
        o_stat.found  = i_ctl.pop && found;
        o_stat.bypass = bypass;
        o_we    = |push_ok;
        o_waddr = {push_lvl, tail_sel};
        o_re    = i_ctl.pop && found && !bypass;
        o_raddr = {pop_lvl, head_sel};
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < NUM_LEVELS; l++) begin
                r_head[l]  <= '0;
                r_tail[l]  <= '0;
                r_count[l] <= '0;
            end
        end else begin
            for (int l = 0; l < NUM_LEVELS; l++) begin
                if (push_ok[l]) begin
                    r_tail[l] <= (r_tail[l] == LAST_PTR) ? '0 : r_tail[l] + 1'b1;
                end
                if (pop_ok[l]) begin
                    r_head[l] <= (r_head[l] == LAST_PTR) ? '0 : r_head[l] + 1'b1;
                end
                r_count[l] <= r_count[l] + CNT_W'(push_ok[l]) - CNT_W'(pop_ok[l]);
            end
        end
    end

    // A pop from memory never hits the entry written in the same cycle
    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_we && o_re) |-> (o_waddr != o_raddr))
        else $error("queue read and write collide");

    // A bypassed pop only happens together with a push into an empty level
    a_bypass_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.bypass |-> (o_we && o_stat.found && (o_waddr[ADDR_W-1:PTR_W] == pop_lvl)))
        else $error("bypass without matching push");

    // Occupancy never passes capacity
    for (genvar g = 0; g < NUM_LEVELS; g++) begin : g_cnt_chk
        a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_count[g] <= FULL)
            else $error("level occupancy overflow");
    end

endmodule

// ===== hw/rtl/multilevel_ready_queue_scheduler.sv =====
// Top level of the multilevel ready-queue scheduler.
//
// Event words enter through a one-word input register and execute from it
// once taken, unless a stalled result holds them there: queue pointers,
// the running table and the queue memory write and read are all settled
// in the cycle the word executes. A reschedule result appears on the output
// register in the next cycle, once the queue memory's registered read
// returns the head process. One word is taken per cycle while the output
// drains; a stalled result holds the input register only when the
// waiting word itself produces a result. Arrivals are queued at level 0,
// I/O completions at level 2 (the last level when fewer exist), expired
// processes at level 1. A push into a full level is dropped. Events for a
// CPU number at or above CPU_COUNT and unused opcodes give no result.
// The queue memory needs no clearing after reset.
module multilevel_ready_queue_scheduler #(
    parameter int CPU_COUNT  = 16,
    parameter int NUM_PROCS  = 256,
    parameter int NUM_LEVELS = 3
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [mlrq_pkg::OP_W-1:0]   i_opcode,
    input  logic [mlrq_pkg::PID_W-1:0]  i_process_id,
    input  logic [mlrq_pkg::CPU_W-1:0]  i_cpu_id,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [mlrq_pkg::CPU_W-1:0]  o_target_cpu,
    output logic [mlrq_pkg::PID_W-1:0]  o_chosen_process,
    output logic                        o_chosen_valid
);

    localparam int PTR_W  = $clog2(NUM_PROCS);
    localparam int LVL_W  = $clog2(NUM_LEVELS);
    localparam int ADDR_W = LVL_W + PTR_W;
    localparam int DEPTH  = NUM_LEVELS * (2 ** PTR_W);
    localparam int CPU_IW = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
    localparam int CMP_W  = (CPU_IW > mlrq_pkg::CPU_W) ? CPU_IW : mlrq_pkg::CPU_W;

    // Input register
    logic                        r_a_valid;
    logic [mlrq_pkg::OP_W-1:0]   r_a_op;
    logic [mlrq_pkg::PID_W-1:0]  r_a_pid;
    logic [mlrq_pkg::CPU_W-1:0]  r_a_cpu;

    // Result register
    logic                        r_b_valid;
    logic [mlrq_pkg::CPU_W-1:0]  r_b_cpu;
    logic [mlrq_pkg::PID_W-1:0]  r_b_pid;
    logic                        r_b_ram;
    logic                        r_b_found;

    // Running table and pending write-back of a process read from memory
    logic                        r_run_valid [CPU_COUNT];
    logic [mlrq_pkg::PID_W-1:0]  r_run_pid   [CPU_COUNT];
    logic                        r_wb_pend;
    logic [CPU_IW-1:0]           r_wb_cpu;

    logic                        cpu_ok;
    logic                        has_res;
    logic                        b_free;
    logic                        exec;
    logic [CMP_W-1:0]            cpu_ext;
    logic [CPU_IW-1:0]           idx;
    logic                        cur_valid;
    logic [mlrq_pkg::PID_W-1:0]  cur_pid;
    logic [mlrq_pkg::PID_W-1:0]  push_pid;
    logic [mlrq_pkg::PID_W-1:0]  direct_pid;
    logic                        uses_ram;
    mlrq_pkg::t_lvl_ctl          lvl_ctl;
    mlrq_pkg::t_lvl_stat         lvl_stat;
    logic                        ram_we;
    logic                        ram_re;
    logic [ADDR_W-1:0]           ram_waddr;
    logic [ADDR_W-1:0]           ram_raddr;
    logic [mlrq_pkg::PID_W-1:0]  ram_rdata;

    // Decode the waiting word and decide whether it may execute
    always_comb begin
        cpu_ext = CMP_W'(r_a_cpu);
        idx     = cpu_ext[CPU_IW-1:0];
        cpu_ok  = 32'(r_a_cpu) < 32'(CPU_COUNT);
        has_res = cpu_ok && ((r_a_op == mlrq_pkg::OP_EXPIRE) ||
                             (r_a_op == mlrq_pkg::OP_YIELD)  ||
                             (r_a_op == mlrq_pkg::OP_IDLE));
        b_free  = !r_b_valid || !i_stall;
        exec    = r_a_valid && (!has_res || b_free);
        o_stall = r_a_valid && !exec;

        // Forward a running process still on its way from memory
        cur_valid = r_run_valid[idx];
        cur_pid   = (r_wb_pend && (r_wb_cpu == idx)) ? ram_rdata : r_run_pid[idx];

        lvl_ctl.push_new = exec && (r_a_op == mlrq_pkg::OP_NEW);
        lvl_ctl.push_io  = exec && (r_a_op == mlrq_pkg::OP_IO_DONE);
        lvl_ctl.push_exp = exec && cpu_ok && (r_a_op == mlrq_pkg::OP_EXPIRE) && cur_valid;
        lvl_ctl.pop      = exec && has_res;

        push_pid   = lvl_ctl.push_exp ? cur_pid : r_a_pid;
        direct_pid = lvl_stat.bypass ? push_pid : '0;
        uses_ram   = lvl_stat.found && !lvl_stat.bypass;
    end

    mlrq_levels #(
        .NUM_PROCS  (NUM_PROCS),
        .NUM_LEVELS (NUM_LEVELS)
    ) u_levels (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (lvl_ctl),
        .o_stat  (lvl_stat),
        .o_we    (ram_we),
        .o_waddr (ram_waddr),
        .o_re    (ram_re),
        .o_raddr (ram_raddr)
    );

    mlrq_ram #(
        .WIDTH (mlrq_pkg::PID_W),
        .DEPTH (DEPTH)
    ) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (push_pid),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Take a new word whenever the input register frees up
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (!r_a_valid || exec) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((!r_a_valid || exec) && i_valid) begin
            r_a_op  <= i_opcode;
            r_a_pid <= i_process_id;
            r_a_cpu <= i_cpu_id;
        end
    end

    // Load the result register, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (lvl_ctl.pop) begin
            r_b_valid <= 1'b1;
        end else if (!i_stall) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (lvl_ctl.pop) begin
            r_b_cpu   <= r_a_cpu;
            r_b_pid   <= direct_pid;
            r_b_ram   <= uses_ram;
            r_b_found <= lvl_stat.found;
        end
    end

    // Running table valid bits and write-back tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CPU_COUNT; c++) begin
                r_run_valid[c] <= 1'b0;
            end
            r_wb_pend <= 1'b0;
        end else begin
            if (lvl_ctl.pop) begin
                r_run_valid[idx] <= lvl_stat.found;
            end
            r_wb_pend <= lvl_ctl.pop && uses_ram;
        end
    end

    // Running table process ids: memory write-back unless a new decision
    // for the same CPU lands in this cycle
    always_ff @(posedge i_clk) begin
        if (r_wb_pend && !(lvl_ctl.pop && (r_wb_cpu == idx))) begin
            r_run_pid[r_wb_cpu] <= ram_rdata;
        end
        if (lvl_ctl.pop) begin
            r_run_pid[idx] <= direct_pid;
        end
        if (lvl_ctl.pop) begin
            r_wb_cpu <= idx;
        end
    end

    assign o_valid          = r_b_valid;
    assign o_target_cpu     = r_b_cpu;
    assign o_chosen_process = r_b_ram ? ram_rdata : r_b_pid;
    assign o_chosen_valid   = r_b_found;

    // A pending write-back always belongs to the result just loaded
    a_wb_matches_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wb_pend |-> (r_b_valid && r_b_ram))
        else $error("write-back without memory-sourced result");

    // An idle decision reports process zero
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_chosen_valid) |-> (o_chosen_process == '0))
        else $error("idle result carries a process id");

    // A memory-sourced result implies a process was found
    a_ram_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_b_ram) |-> o_chosen_valid)
        else $error("memory read for an idle decision");

    // A result waiting under stall keeps the register from being reloaded
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && i_stall) |-> !lvl_ctl.pop)
        else $error("result overwritten while stalled");

endmodule
